@@ hw/rtl/blzss_pkg.sv @@
// Shared constants, types and command/status structs for the backward LZSS decompressor.
package blzss_pkg;

  localparam int WINDOW_DEPTH = 8192;
  localparam int WP_W         = $clog2(WINDOW_DEPTH);
  localparam int CAP_W        = 24;
  localparam int LEN_W        = 5;
  localparam int DIST_W       = 13;
  localparam int FLAGS_W      = 4;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 24'hFFFFFF;
  localparam logic [FLAGS_W-1:0] FLAGS_FULL  = 4'd8;
  localparam logic [LEN_W-1:0]   LEN_BIAS    = 5'd3;
  localparam logic [DIST_W-1:0]  DIST_BIAS   = 13'd3;
  localparam logic [ADDR_W-1:0]  REG_OUT_CAP = 3'd0;

  typedef struct packed {
    logic take_in;
    logic load_flags;
    logic shift_flags;
    logic hold_pair;
    logic clr_pending;
    logic end_clear;
    logic set_failed;
    logic start_copy;
    logic mem_rd;
    logic copy_push;
    logic res_load;
    logic res_lit;
    logic res_err;
    logic res_last;
    logic emit_res;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic failed;
    logic pending;
    logic full;
    logic flags_zero;
    logic flag_msb;
    logic ref_bad;
    logic out_free;
    logic cnt_one;
  } sts_t;

endpackage

@@ hw/rtl/blzss_ifs.sv @@
// Valid/ready channel interfaces for compressed input beats and result beats.
interface blzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] comp_byte;
  logic       final_byte;

  modport source (output valid, comp_byte, final_byte, input ready);
  modport sink   (input valid, comp_byte, final_byte, output ready);
endinterface

interface blzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       is_last;
  logic       error;

  modport source (output valid, out_byte, byte_valid, is_last, error, input ready);
  modport sink   (input valid, out_byte, byte_valid, is_last, error, output ready);
endinterface

@@ hw/rtl/backward_lzss_decompressor.sv @@
// Top level of the backward LZSS decompressor: channels, register port, controller and datapath.
// One compressed beat is taken at a time. A control byte, a dropped byte or the high
// byte of a reference is decoded, passing the emit state when it returns a marker; a
// literal or an error marker passes the emit state; a reference low byte copies 3 to 18
// bytes, each with one history read and one write/output step on the 8192-byte window
// memory. A stalled output holds the emit and write steps. Register output_capacity sits
// at byte address 0; the user must write it only while idle (the block does not enforce it).
module backward_lzss_decompressor (
  input  logic                            clk,
  input  logic                            rst_n,
  blzss_in_if.sink                        in_ch,
  blzss_out_if.source                     out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [blzss_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [blzss_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [blzss_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                            cfg_pready
);
  import blzss_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             cfg_we;
  logic [CAP_W-1:0] cap;
  logic             in_ready;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == REG_OUT_CAP);
  assign cfg_prdata = (cfg_paddr == REG_OUT_CAP) ? DATA_W'(cap) : '0;
  assign in_ch.ready = in_ready;

  blzss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  blzss_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_comp_byte   (in_ch.comp_byte),
    .in_final_byte  (in_ch.final_byte),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_pwdata[CAP_W-1:0]),
    .cfg_cap        (cap),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_byte       (out_ch.out_byte),
    .out_byte_valid (out_ch.byte_valid),
    .out_is_last    (out_ch.is_last),
    .out_error      (out_ch.error)
  );

endmodule

@@ hw/rtl/blzss_ctrl.sv @@
// Controller state machine: decodes each beat and sequences literal, marker and copy output.
module blzss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  blzss_pkg::sts_t sts,
  output blzss_pkg::cmd_t cmd
);
  import blzss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_EMIT = 5'b00100,
    S_RD   = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.end_clear = sts.fin;
        state_nxt     = S_IDLE;
        if (sts.failed) begin
          if (sts.fin) begin
            cmd.res_load = 1'b1;
            cmd.res_err  = 1'b1;
            cmd.res_last = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else if (sts.pending) begin
          cmd.clr_pending = 1'b1;
          if (sts.ref_bad) begin
            cmd.set_failed = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_err    = 1'b1;
            cmd.res_last   = sts.fin;
            state_nxt      = S_EMIT;
          end else begin
            cmd.start_copy = 1'b1;
            state_nxt      = S_RD;
          end
        end else if (sts.full) begin
          if (sts.fin) begin
            cmd.res_load = 1'b1;
            cmd.res_last = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else if (sts.flags_zero) begin
          cmd.load_flags = 1'b1;
          if (sts.fin) begin
            cmd.res_load = 1'b1;
            cmd.res_last = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else begin
          cmd.shift_flags = 1'b1;
          if (sts.flag_msb) begin
            if (sts.fin) begin
              cmd.set_failed = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_err    = 1'b1;
              cmd.res_last   = 1'b1;
              state_nxt      = S_EMIT;
            end else begin
              cmd.hold_pair = 1'b1;
            end
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_lit  = 1'b1;
            cmd.res_last = sts.fin;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.copy_push = 1'b1;
          state_nxt     = sts.cnt_one ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/blzss_dp.sv @@
// Datapath: parse state, history window memory, copy counters and output register.
module blzss_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  blzss_pkg::cmd_t              cmd,
  output blzss_pkg::sts_t              sts,
  input  logic [7:0]                   in_comp_byte,
  input  logic                         in_final_byte,
  input  logic                         cfg_we,
  input  logic [blzss_pkg::CAP_W-1:0]  cfg_wdata,
  output logic [blzss_pkg::CAP_W-1:0]  cfg_cap,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic                         out_byte_valid,
  output logic                         out_is_last,
  output logic                         out_error
);
  import blzss_pkg::*;

  logic [7:0]         history [WINDOW_DEPTH];
  logic [7:0]         mem_q_r;

  logic [CAP_W-1:0]   cap_r;
  logic [7:0]         flag_byte_r, flag_byte_nxt;
  logic [FLAGS_W-1:0] flags_left_r, flags_left_nxt;
  logic [7:0]         pair_high_r;
  logic               pending_r, pending_nxt;
  logic               failed_r;
  logic [WP_W-1:0]    wp_r;
  logic [CAP_W-1:0]   bw_r;
  logic [7:0]         in_byte_r;
  logic               in_fin_r;
  logic [LEN_W-1:0]   cnt_r;
  logic [WP_W-1:0]    rd_ptr_r;
  logic [7:0]         res_byte_r;
  logic               res_valid_r, res_last_r, res_err_r;
  logic               out_v_r;
  logic [7:0]         out_byte_r;
  logic               out_bv_r, out_last_r, out_err_r;

  logic [LEN_W-1:0]   len;
  logic [DIST_W-1:0]  ref_dist;
  logic [CAP_W:0]     bw_plus_len;
  logic [WP_W:0]      wp_ext, dist_ext, src_start;
  logic               store;
  logic [7:0]         store_data;

  assign len         = LEN_W'(pair_high_r[7:4]) + LEN_BIAS;
  assign ref_dist    = {1'b0, pair_high_r[3:0], in_byte_r} + DIST_BIAS;
  assign bw_plus_len = {1'b0, bw_r} + (CAP_W+1)'(len);
  assign wp_ext      = {1'b0, wp_r};
  assign dist_ext    = (WP_W+1)'(ref_dist);
  assign src_start   = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                            : (wp_ext + (WP_W+1)'(WINDOW_DEPTH) - dist_ext);

  assign sts.fin        = in_fin_r;
  assign sts.failed     = failed_r;
  assign sts.pending    = pending_r;
  assign sts.full       = (bw_r >= cap_r);
  assign sts.flags_zero = (flags_left_r == '0);
  assign sts.flag_msb   = flag_byte_r[7];
  assign sts.ref_bad    = (bw_plus_len > {1'b0, cap_r}) || (CAP_W'(ref_dist) > bw_r);
  assign sts.out_free   = !out_v_r || out_ready;
  assign sts.cnt_one    = (cnt_r == LEN_W'(1));

  assign store      = (cmd.emit_res && res_valid_r) || cmd.copy_push;
  assign store_data = cmd.copy_push ? mem_q_r : res_byte_r;

  always_comb begin
    flag_byte_nxt  = flag_byte_r;
    flags_left_nxt = flags_left_r;
    pending_nxt    = pending_r;
    if (cmd.load_flags) begin
      flag_byte_nxt  = in_byte_r;
      flags_left_nxt = FLAGS_FULL;
    end else if (cmd.shift_flags) begin
      flag_byte_nxt  = {flag_byte_r[6:0], 1'b0};
      flags_left_nxt = flags_left_r - FLAGS_W'(1);
    end
    if (cmd.hold_pair) begin
      pending_nxt = 1'b1;
    end
    if (cmd.clr_pending) begin
      pending_nxt = 1'b0;
    end
    if (cmd.end_clear) begin
      flags_left_nxt = '0;
      pending_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      history[wp_r] <= store_data;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= history[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      flag_byte_r  <= '0;
      flags_left_r <= '0;
      pair_high_r  <= '0;
      pending_r    <= 1'b0;
      failed_r     <= 1'b0;
      wp_r         <= '0;
      bw_r         <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      flag_byte_r  <= flag_byte_nxt;
      flags_left_r <= flags_left_nxt;
      pending_r    <= pending_nxt;
      if (cmd.hold_pair) begin
        pair_high_r <= in_byte_r;
      end
      if (cmd.set_failed) begin
        failed_r <= 1'b1;
      end
      if (store) begin
        wp_r <= (wp_r == WP_W'(WINDOW_DEPTH - 1)) ? '0 : wp_r + WP_W'(1);
        bw_r <= bw_r + CAP_W'(1);
      end
      if (cmd.emit_res || cmd.copy_push) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_byte_r <= in_comp_byte;
      in_fin_r  <= in_final_byte;
    end
    if (cmd.start_copy) begin
      cnt_r    <= len;
      rd_ptr_r <= src_start[WP_W-1:0];
    end else if (cmd.copy_push) begin
      cnt_r    <= cnt_r - LEN_W'(1);
      rd_ptr_r <= (rd_ptr_r == WP_W'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_r + WP_W'(1);
    end
    if (cmd.res_load) begin
      res_byte_r  <= cmd.res_lit ? in_byte_r : 8'h00;
      res_valid_r <= cmd.res_lit;
      res_last_r  <= cmd.res_last;
      res_err_r   <= cmd.res_err;
    end
    if (cmd.emit_res) begin
      out_byte_r <= res_byte_r;
      out_bv_r   <= res_valid_r;
      out_last_r <= res_last_r;
      out_err_r  <= res_err_r;
    end else if (cmd.copy_push) begin
      out_byte_r <= mem_q_r;
      out_bv_r   <= 1'b1;
      out_last_r <= in_fin_r && sts.cnt_one;
      out_err_r  <= 1'b0;
    end
  end

  assign cfg_cap        = cap_r;
  assign out_valid      = out_v_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_is_last    = out_last_r;
  assign out_error      = out_err_r;

endmodule

@@ hw/rtl/blzss_chk.sv @@
// Port-level checker for the backward LZSS decompressor, bound to the top level.
module blzss_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_is_last,
  input logic       out_error
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_byte_valid)
                                && $stable(out_is_last) && $stable(out_error))
    else $error("stalled result beat changed");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte_valid && out_error))
    else $error("error marker carries data");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00)
    else $error("marker beat has nonzero byte");

endmodule

bind backward_lzss_decompressor blzss_chk u_blzss_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_byte_valid (out_ch.byte_valid),
  .out_is_last    (out_ch.is_last),
  .out_error      (out_ch.error)
);
